/* sv/assert_macros.svh */
// Assertion helpers used by ray_box_slab_intersect.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RBSI_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBSI_ASSERT(lbl, prop, msg) \
   `RBSI_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define RBSI_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define RBSI_ASSERT(lbl, prop, msg)
`endif
`endif

/* sv/rbsi_pkg.sv */
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TOL_WIDTH = 16;
   localparam int DIST_WIDTH = 31;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = 31'h7FFF_FFFF;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

   typedef enum logic [0:0] {
      REG_PARALLEL_TOL = 1'b0
   } reg_index_type;

   // per-axis control that rides along with the quotients
   typedef struct packed {
      logic neg_lo;    // lo crossing is negative
      logic neg_hi;    // hi crossing is negative
      logic parallel;  // slab treated as parallel
      logic par_miss;  // parallel and origin outside slab
   } axis_ctl_type;

endpackage

/* sv/rbsi_div_pipe.sv */
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rbsi_div_pipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);
   import rbsi_pkg::*;

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_i;
      logic [NUM_W-1:0] num_i;
      logic [NUM_W-1:0] quo_i;
      logic [DEN_W-1:0] den_i;
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] rem_in;
      logic             bit_in;

      if (k == 0) begin : g_first
         assign rem_i = '0;
         assign num_i = num;
         assign quo_i = '0;
         assign den_i = den;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign num_i = num_ff[k-1];
         assign quo_i = quo_ff[k-1];
         assign den_i = den_ff[k-1];
      end

      always_comb begin
         trial = {rem_i, num_i[NUM_W-1]};
         if (trial >= {1'b0, den_i}) begin
            bit_in = 1'b1;
            rem_in = DEN_W'(trial - {1'b0, den_i});
         end else begin
            bit_in = 1'b0;
            rem_in = trial[DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {num_i[NUM_W-2:0], 1'b0};
            quo_ff[k] <= {quo_i[NUM_W-2:0], bit_in};
            den_ff[k] <= den_i;
         end
      end
   end

   assign quo = quo_ff[NUM_W-1];

endmodule

/* sv/ray_box_slab_intersect.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box by the slab test, signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Pipeline: stage 1, one divider stage per quotient bit, stage A and the
//   output register of stage B.
// Throughput: one transaction per cycle; the whole pipe holds only while a
//   result sits in the output register and rsp_tready is low.
// Reset: synchronous, active high; clears all valid bits and loads
//   parallel_tolerance with 1.
`include "assert_macros.svh"

module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   // origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z (low bits first)
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // hit [0], entry_distance [31:1]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rbsi_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int NW = W + FRAC_BITS;             // dividend / quotient width
   localparam logic [NW-1:0] LIM_POS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NW-1:0] LIM_NEG = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   // ---------------- config register ----------------
   logic [TOL_WIDTH-1:0] tol_ff;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_PARALLEL_TOL);
   assign csr_prdata = (csr_paddr[2] == REG_PARALLEL_TOL) ?
                       {{(32-TOL_WIDTH){1'b0}}, tol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr) begin
         tol_ff <= csr_pwdata[TOL_WIDTH-1:0];
      end
   end

   // ---------------- flow control ----------------
   // Global enable: every stage moves when the output register is free.
   logic en;
   logic out_vld_ff;
   logic [31:0] out_data_ff;

   assign en = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: differences, magnitudes, parallel test ------
   logic [NW-1:0]      num_in  [3][2];
   logic [W-1:0]       den_in  [3];
   axis_ctl_type [2:0] ctl_in;

   for (genvar a = 0; a < 3; a++) begin : g_prep
      logic signed [W-1:0] o, d, lo, hi;
      logic [W:0]   dl, dh;
      logic [W-1:0] ml, mh, md;

      assign o  = req_tdata[a*W +: W];
      assign d  = req_tdata[(3+a)*W +: W];
      assign lo = req_tdata[(6+a)*W +: W];
      assign hi = req_tdata[(9+a)*W +: W];

      always_comb begin
         dl = {lo[W-1], lo} - {o[W-1], o};
         dh = {hi[W-1], hi} - {o[W-1], o};
         ml = dl[W] ? W'(-dl) : dl[W-1:0];
         mh = dh[W] ? W'(-dh) : dh[W-1:0];
         md = d[W-1] ? W'(-d) : d;
         num_in[a][0] = {ml, {FRAC_BITS{1'b0}}};
         num_in[a][1] = {mh, {FRAC_BITS{1'b0}}};
         den_in[a] = md;
         ctl_in[a].neg_lo   = dl[W] ^ d[W-1];
         ctl_in[a].neg_hi   = dh[W] ^ d[W-1];
         ctl_in[a].parallel = (md == '0) || (md < {{(W-TOL_WIDTH){1'b0}}, tol_ff});
         ctl_in[a].par_miss = (o < lo) || (o > hi);
      end
   end

   logic [NW-1:0]      num_ff [3][2];
   logic [W-1:0]       den_ff [3];
   axis_ctl_type [2:0] ctl1_ff;
   logic               vld1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         ctl1_ff <= ctl_in;
      end
   end

   // ---------------- divider stages ----------------
   logic [NW-1:0] quo [3][2];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      for (genvar c = 0; c < 2; c++) begin : g_div
         rbsi_div_pipe #(.NUM_W(NW), .DEN_W(W)) u_div (
            .clock (clock),
            .en    (en),
            .num   (num_ff[a][c]),
            .den   (den_ff[a]),
            .quo   (quo[a][c])
         );
      end
   end

   // control and valid ride alongside the dividers
   axis_ctl_type [2:0] ctl_pipe_ff [NW];
   logic [NW-1:0]      vld_pipe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_pipe_ff <= '0;
      end else if (en) begin
         vld_pipe_ff <= {vld_pipe_ff[NW-2:0], vld1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_pipe_ff[0] <= ctl1_ff;
         for (int k = 1; k < NW; k++) begin
            ctl_pipe_ff[k] <= ctl_pipe_ff[k-1];
         end
      end
   end

   // ---------------- stage A: saturate, sign, order ----------------
   logic signed [W-1:0] tmin_in [3];
   logic signed [W-1:0] tmax_in [3];
   axis_ctl_type [2:0]  ctl_d;

   assign ctl_d = ctl_pipe_ff[NW-1];

   for (genvar a = 0; a < 3; a++) begin : g_order
      logic signed [W-1:0] t [2];
      logic [NW-1:0] lim [2];
      logic [NW-1:0] qs  [2];
      logic          neg [2];

      always_comb begin
         neg[0] = ctl_d[a].neg_lo;
         neg[1] = ctl_d[a].neg_hi;
         for (int c = 0; c < 2; c++) begin
            lim[c] = neg[c] ? LIM_NEG : LIM_POS;
            qs[c]  = (quo[a][c] > lim[c]) ? lim[c] : quo[a][c];
            t[c]   = neg[c] ? W'(-qs[c][W-1:0]) : qs[c][W-1:0];
         end
         if (t[0] > t[1]) begin
            tmin_in[a] = t[1];
            tmax_in[a] = t[0];
         end else begin
            tmin_in[a] = t[0];
            tmax_in[a] = t[1];
         end
      end
   end

   logic signed [W-1:0] tmin_ff [3];
   logic signed [W-1:0] tmax_ff [3];
   axis_ctl_type [2:0]  ctla_ff;
   logic                vlda_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff <= 1'b0;
      end else if (en) begin
         vlda_ff <= vld_pipe_ff[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         ctla_ff <= ctl_d;
      end
   end

   // ---------------- stage B: narrow interval, output register ----------
   // Entry only grows and exit only shrinks, so a miss at any non-parallel axis
   // is the same as entry > exit after all three axes.
   logic signed [W-1:0] entry, exit_t;
   logic                miss;
   logic [W+30:0]       ext;
   logic [DIST_WIDTH-1:0] dist_sat;

   always_comb begin
      entry  = '0;
      exit_t = {1'b0, {(W-1){1'b1}}};
      miss   = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (ctla_ff[a].parallel) begin
            miss = miss || ctla_ff[a].par_miss;
         end else begin
            if (tmin_ff[a] > entry) entry = tmin_ff[a];
            if (tmax_ff[a] < exit_t) exit_t = tmax_ff[a];
         end
      end
      miss = miss || (entry > exit_t);
      ext  = {{DIST_WIDTH{1'b0}}, entry};
      dist_sat = (ext > {{W{1'b0}}, DIST_MAX}) ? DIST_MAX : ext[DIST_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vlda_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= miss ? 32'd0 : {dist_sat, 1'b1};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------- assertions ----------------
   `RBSI_ASSERT(a_miss_zero, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[31:1] == '0, "miss carries nonzero distance")
   `RBSI_ASSERT(a_stall_only_when_full, !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled without output back-pressure")
   `RBSI_ASSERT(a_tol_write, csr_wr |=> tol_ff == $past(csr_pwdata[TOL_WIDTH-1:0]), "tolerance register not written")
   `RBSI_ASSERT(a_hold_out, out_vld_ff && !en |=> out_vld_ff && $stable(out_data_ff), "output register changed during stall")

endmodule

/* tb/ray_box_slab_intersect_checker.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_checker
// Watches the req, rsp and csr ports, predicts each hit/distance result from
// the accepted ray/box pair and compares it with the result the block returns.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_checker #(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count,
   output int          hit_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rbsi_pkg::*;

   typedef struct packed {
      logic                  hit;
      logic [DIST_WIDTH-1:0] dist_val;
   } slab_result_type;

   logic [TOL_WIDTH-1:0] tol_q;
   slab_result_type      expected_results[$];

   // (corner - origin) / dir in Q16.16, truncated, saturated to the coord range
   function automatic longint slab_crossing(longint corner, longint origin, longint dir);
      logic             neg;
      longint unsigned  diff;
      longint unsigned  mag;
      longint unsigned  lim;
      longint unsigned  q;
      neg  = (corner < origin) ^ (dir < 0);
      diff = (corner < origin) ? longint'(origin - corner) : longint'(corner - origin);
      mag  = (dir < 0) ? -dir : dir;
      lim  = neg ? (64'd1 << (COORD_WIDTH-1)) : (64'd1 << (COORD_WIDTH-1)) - 1;
      q    = (diff << FRAC_BITS) / mag;
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic slab_result_type slab_test(
      input logic [((12*COORD_WIDTH+7)/8)*8-1:0] pair,
      input logic [TOL_WIDTH-1:0] tol);
      slab_result_type r;
      longint o, d, lo, hi, t1, t2, t, entry, exit_t;
      longint unsigned mag;
      logic miss;
      entry  = 0;
      exit_t = (64'd1 << (COORD_WIDTH-1)) - 1;
      miss   = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!miss) begin
            o   = longint'($signed(pair[COORD_WIDTH*a +: COORD_WIDTH]));
            d   = longint'($signed(pair[COORD_WIDTH*(3+a) +: COORD_WIDTH]));
            lo  = longint'($signed(pair[COORD_WIDTH*(6+a) +: COORD_WIDTH]));
            hi  = longint'($signed(pair[COORD_WIDTH*(9+a) +: COORD_WIDTH]));
            mag = (d < 0) ? -d : d;
            if (mag == 0 || mag < tol) begin
               if (o < lo || o > hi) miss = 1'b1;
            end else begin
               t1 = slab_crossing(lo, o, d);
               t2 = slab_crossing(hi, o, d);
               if (t1 > t2) begin
                  t = t1; t1 = t2; t2 = t;
               end
               if (t1 > entry) entry = t1;
               if (t2 < exit_t) exit_t = t2;
               if (entry > exit_t) miss = 1'b1;
            end
         end
      end
      r.hit      = !miss;
      r.dist_val = miss ? '0 :
                   (entry > longint'(DIST_MAX) ? DIST_MAX : entry[DIST_WIDTH-1:0]);
      return r;
   endfunction

   always @(posedge clock) begin
      slab_result_type exp_r;
      slab_result_type got;
      if (reset) begin
         tol_q <= TOL_RESET;
         expected_results.delete();
         fail_count   <= 0;
         hit_count    <= 0;
         result_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && reg_index_type'(csr_paddr >> 2) == REG_PARALLEL_TOL
             && (csr_paddr >> 2) == 0)
            tol_q <= csr_pwdata[TOL_WIDTH-1:0];
         if (req_tvalid && req_tready)
            expected_results.push_back(slab_test(req_tdata, tol_q));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[31:1]};
            result_count <= result_count + 1;
            if (got.hit) hit_count <= hit_count + 1;
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected rsp transaction hit=%0b dist=%08h",
                           got.hit, got.dist_val);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.hit !== got.hit || exp_r.dist_val !== got.dist_val) begin
                  if (fail_count < 10)
                     $display({"ERROR: rsp mismatch: expected hit=%0b dist=%08h,",
                               " got hit=%0b dist=%08h"},
                              exp_r.hit, exp_r.dist_val, got.hit, got.dist_val);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = expected_results.size();

endmodule

/* tb/ray_box_slab_intersect_tb.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_tb
// Drives ray/box pairs through the slab intersection block under several
// parallel tolerance settings, with random stalls on both sides; a separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbsi_pkg::*;

   localparam int CW        = 32;
   localparam int DW        = ((12*CW+7)/8)*8;
   localparam int LATENCY   = CW + 19;
   localparam int CYCLE_CAP = 400000;   // far above the slowest legal run

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [DW-1:0] req_tdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [2:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   int  fail_count, pending_count, hit_count, result_count;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  steady = 1'b0;   // no idling on either side while set

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ray_box_slab_intersect #(.COORD_WIDTH(CW)) u_dut (.*);

   ray_box_slab_intersect_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock, .reset, .req_tdata, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tvalid, .rsp_tready,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending_count, .hit_count, .result_count);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // result side back-pressure, ~22% stall
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 22);

   // one req transaction; valid stays high into the next item unless we idle
   task automatic send_pair(input logic [DW-1:0] pair);
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // drain everything, then give the pipe its latency before touching CSRs
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DW-1:0] pack_pair(input logic [CW-1:0] f [12]);
      logic [DW-1:0] p;
      p = '0;
      for (int i = 0; i < 12; i++) p[CW*i +: CW] = f[i];
      return p;
   endfunction

   function automatic logic [CW-1:0] signed_span(input int unsigned span);
      return CW'($urandom_range(2*span)) - CW'(span);
   endfunction

   // box around a random center, each slab inverted one time in twenty; ray aimed from nearby
   function automatic logic [DW-1:0] shaped_pair(input logic [15:0] tol);
      logic [CW-1:0] f [12];
      logic [CW-1:0] ctr, half;
      int            pick;
      for (int a = 0; a < 3; a++) begin
         ctr      = signed_span(1 << 20);
         half     = $urandom_range(1 << 18);
         f[6+a]   = ctr - half;
         f[9+a]   = ctr + half;
         if ($urandom_range(19) == 0) begin       // inverted slab
            f[6+a] = ctr + half;
            f[9+a] = ctr - half;
         end
         f[a]     = ctr + signed_span(1 << 20);
         pick     = $urandom_range(9);
         if (pick == 0)      f[3+a] = '0;
         else if (pick == 1) f[3+a] = CW'(tol) + signed_span(2);   // around tolerance
         else if (pick == 2) f[3+a] = -(CW'(tol)) + signed_span(2);
         else                f[3+a] = signed_span(1 << 17);
      end
      return pack_pair(f);
   endfunction

   function automatic logic [DW-1:0] noise_pair();
      logic [CW-1:0] f [12];
      for (int i = 0; i < 12; i++) f[i] = $urandom;
      return pack_pair(f);
   endfunction

   task automatic random_phase(input int count, input logic [15:0] tol);
      for (int n = 0; n < count; n++) begin
         steady = (n >= count/3 && n < count/3 + 40);
         if ($urandom_range(99) < 80) send_pair(shaped_pair(tol));
         else                         send_pair(noise_pair());
      end
      steady = 1'b0;
   endtask

   // one directed pair from per-axis origin/dir/min/max, same on all axes
   task automatic send_uniform(input logic [CW-1:0] o, d, lo, hi);
      logic [CW-1:0] f [12];
      for (int a = 0; a < 3; a++) begin
         f[a] = o; f[3+a] = d; f[6+a] = lo; f[9+a] = hi;
      end
      send_pair(pack_pair(f));
   endtask

   localparam logic [CW-1:0] ONE  = 32'h0001_0000;
   localparam logic [CW-1:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] SMIN = 32'h8000_0000;

   initial begin
      logic [CW-1:0] f [12];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset tolerance
      send_uniform(0, 0, -ONE, ONE);                  // all parallel, inside
      send_uniform(2*ONE, 0, -ONE, ONE);              // parallel, outside
      send_uniform(ONE, 0, -ONE, ONE);                // parallel, on bound
      send_uniform(0, ONE, -ONE, ONE);                // origin inside
      send_uniform(-4*ONE, ONE, -ONE, ONE);           // hit from outside
      send_uniform(4*ONE, ONE, -ONE, ONE);            // box behind ray
      send_uniform(4*ONE, -ONE, -ONE, ONE);           // negative direction hit
      send_uniform(SMIN, 1, SMAX, SMAX);              // quotient saturates high
      send_uniform(SMAX, 1, SMIN, SMIN);              // saturates low
      send_uniform(SMIN, SMIN, SMIN, SMAX);
      send_uniform(SMAX, SMAX, SMIN, SMAX);
      send_uniform(SMIN, 32'h7FFF_FFFF, SMAX, SMIN);  // inverted box
      send_uniform(0, 0, ONE, -ONE);                  // inverted, parallel
      send_uniform(-3*ONE, 3, -ONE, ONE);             // tiny non-parallel dir
      send_uniform(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_uniform(-2*ONE, 3*ONE, -ONE, ONE);         // truncated quotient
      for (int a = 0; a < 3; a++) begin                // miss on the z slab only
         f[a] = -4*ONE; f[3+a] = ONE; f[6+a] = -ONE; f[9+a] = ONE;
      end
      f[2] = 0; f[5] = ONE; f[8] = 8*ONE; f[11] = 9*ONE;
      send_pair(pack_pair(f));
      drain();

      // tolerance zero: only an exact zero counts as parallel
      csr_write(3'(REG_PARALLEL_TOL) << 2, 32'hFFFF_0000);
      send_uniform(0, 0, -ONE, ONE);
      send_uniform(-2*ONE, 1, -ONE, ONE);
      send_uniform(-2*ONE, -1, -ONE, ONE);
      random_phase(200, 16'h0000);
      drain();

      // largest tolerance
      csr_write(3'(REG_PARALLEL_TOL) << 2, 32'h0000_FFFF);
      send_uniform(0, 32'h0000_FFFE, -ONE, ONE);
      send_uniform(0, 32'h0000_FFFF, -ONE, ONE);
      send_uniform(5*ONE, 32'hFFFF_0002, -ONE, ONE);
      random_phase(200, 16'hFFFF);
      drain();

      // write to an unmapped address is ignored
      csr_write(3'd4, 32'h0000_0007);
      csr_write(3'(REG_PARALLEL_TOL) << 2, 32'h0000_1000);
      random_phase(210, 16'h1000);
      drain();

      csr_write(3'(REG_PARALLEL_TOL) << 2, 32'h0000_0001);
      random_phase(210, 16'h0001);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d ray/box pairs over five tolerance settings; %0d results, %0d hits.",
               items_sent, result_count, hit_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/rbsi_pkg.sv
sv/rbsi_div_pipe.sv
sv/ray_box_slab_intersect.sv
tb/ray_box_slab_intersect_checker.sv
tb/ray_box_slab_intersect_tb.sv
